// ===== rtl/fnrs_pkg.sv =====
package fnrs_pkg;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_FRAME_ROWS = 1'b1;

  // Register and coordinate widths
  localparam int REG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 11;

  // Reset values of the frame geometry
  localparam logic [REG_W-1:0] LINE_WIDTH_RESET = 12'd1080;
  localparam logic [REG_W-1:0] FRAME_ROWS_RESET = 12'd1920;

  // Smallest frame dimension that still has an interior
  localparam int MIN_DIM = 3;

  // Configuration write strobe group
  typedef struct packed {
    logic             en;
    logic             index;
    logic [REG_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/four_neighbor_rgb_smoothing.sv =====
// Channel  | Dir | Fields (low bit first)                                 | Accepted when
// s_axis   | in  | tdata: red, green, blue                                | tvalid & tready
// m_axis   | out | tdata: avg_red, avg_green, avg_blue, out_row, out_col; | tvalid & tready
//          |     | tlast: frame_last                                      |
// wr       | in  | wr_addr: register index, wr_data: value                | wr_en
//
// One pixel per clock, sustained while the output accepts. A smoothed pixel is made
// from the pixel below it: memory reads and compute stage load when that pixel is
// accepted, and the output register loads from the compute stage when it moves.
// The two line memories each take one write and their reads in the same cycle,
// which sets the one pixel per clock figure.
// rst (synchronous) clears counters and valid flags and reloads the reset geometry; line memories are not cleared.
// A stalled output holds the compute stage, and the input then stalls behind it.
module four_neighbor_rgb_smoothing
  import fnrs_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk,
  input  logic rst,

  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // red, green, blue
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      s_axis_tdata,

  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // avg_red, avg_green, avg_blue, out_row, out_col
  output logic [((3*CHANNEL_BITS+ROW_W+COL_OUT_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                                     m_axis_tlast,

  input  logic             wr_en,
  input  logic             wr_addr,
  input  logic [REG_W-1:0] wr_data
);

  localparam int CB    = CHANNEL_BITS;
  localparam int PX_W  = 3 * CB;
  localparam int OUT_W = ((PX_W + ROW_W + COL_OUT_W + 7) / 8) * 8;
  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = ((WW > REG_W) ? WW : REG_W) + 1;

  cfg_wr_t cfg;

  logic [REG_W-1:0] line_width;
  logic [REG_W-1:0] frame_rows;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_count;

  logic [CMP_W-1:0] w_eff, h_eff, c_ext, r_ext;
  logic             emit, is_last;
  logic [ROW_W-1:0] row_next;
  logic [CW-1:0]    col_next;
  logic [CW-1:0]    right_addr;
  logic [PX_W-1:0]  px;
  logic             in_acc;

  // Line memories
  logic [PX_W-1:0] middle_line [MAX_WIDTH];
  logic [PX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PX_W-1:0] mid_rd_c, mid_rd_r, up_rd;
  logic            up_wr_pending;
  logic [CW-1:0]   up_wr_addr;

  // Compute stage
  logic                 s1_valid;
  logic [PX_W-1:0]      s1_px, s1_left;
  logic [ROW_W-1:0]     s1_row;
  logic [COL_OUT_W-1:0] s1_col;
  logic                 s1_last;
  logic                 s1_move;
  logic [PX_W-1:0]      avg;
  logic [OUT_W-1:0]     out_word;

  assign cfg = '{en: wr_en, index: wr_addr, data: wr_data};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      frame_rows <= FRAME_ROWS_RESET;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_LINE_WIDTH: line_width <= cfg.data;
        REG_FRAME_ROWS: frame_rows <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp geometry, decide emission and advance counters
  always_comb begin
    w_eff = CMP_W'(line_width);
    if (w_eff < CMP_W'(MIN_DIM)) w_eff = CMP_W'(MIN_DIM);
    if (w_eff > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
    h_eff = CMP_W'(frame_rows);
    if (h_eff < CMP_W'(MIN_DIM)) h_eff = CMP_W'(MIN_DIM);

    c_ext = CMP_W'(col_count);
    r_ext = CMP_W'(row_count);

    emit = (r_ext >= CMP_W'(2)) && (r_ext + CMP_W'(1) <= h_eff) &&
           (c_ext >= CMP_W'(1)) && (c_ext + CMP_W'(2) <= w_eff);
    is_last = (r_ext + CMP_W'(1) == h_eff) && (c_ext + CMP_W'(2) == w_eff);

    if (c_ext + CMP_W'(1) >= w_eff) begin
      col_next = '0;
      row_next = (r_ext + CMP_W'(1) >= h_eff) ? '0 : row_count + ROW_W'(1);
    end else begin
      col_next = col_count + CW'(1);
      row_next = row_count;
    end

    right_addr = CW'(c_ext + CMP_W'(1));
    px = s_axis_tdata[PX_W-1:0];
  end

  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  // Middle line: read current and right column, write the new pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_rd_c                <= middle_line[col_count];
      mid_rd_r                <= middle_line[right_addr];
      middle_line[col_count]  <= px;
    end
  end

  // Upper line: read the top neighbor, copy the old middle entry from the middle line read register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rd <= upper_line[col_count];
    end
    if (up_wr_pending) begin
      upper_line[up_wr_addr] <= mid_rd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_wr_pending <= 1'b0;
    end else begin
      up_wr_pending <= in_acc;
    end
    up_wr_addr <= col_count;
  end

  // Compute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= emit;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_px   <= px;
      s1_left <= mid_rd_c;
      s1_row  <= row_count - ROW_W'(1);
      s1_col  <= COL_OUT_W'(c_ext);
      s1_last <= is_last;
    end
  end

  // Sum the four neighbors per channel and drop two bits
  always_comb begin
    logic [CB+1:0] sum;
    avg = '0;
    for (int k = 0; k < 3; k++) begin
      sum = (CB+2)'(s1_left[k*CB +: CB]) + (CB+2)'(mid_rd_r[k*CB +: CB]) +
            (CB+2)'(up_rd[k*CB +: CB]) + (CB+2)'(s1_px[k*CB +: CB]);
      avg[k*CB +: CB] = sum[CB+1:2];
    end
    out_word = '0;
    out_word[PX_W-1:0] = avg;
    out_word[PX_W +: ROW_W] = s1_row;
    out_word[PX_W+ROW_W +: COL_OUT_W] = s1_col;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (s1_move) begin
      m_axis_tdata <= out_word;
      m_axis_tlast <= s1_last;
    end
  end

  // Input stalls only behind a waiting compute stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with empty compute stage");

  // Only interior pixels reach the compute stage
  a_interior: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_col != '0) && (s1_row != '0))
    else $error("border pixel in compute stage");

  // Counters start a frame at origin after reset
  a_reset_origin: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (row_count == '0) && (col_count == '0))
    else $error("counters not cleared by reset");

  // A pending upper line copy follows an accepted word
  a_copy_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> up_wr_pending && (up_wr_addr == $past(col_count)))
    else $error("upper line copy lost");

endmodule

// ===== tb/sv/tb_four_neighbor_rgb_smoothing.sv =====
module tb_four_neighbor_rgb_smoothing;
  import fnrs_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int CH_BITS      = 8;
  localparam int PIX_W        = ((3*CH_BITS+7)/8)*8;
  localparam int OUT_W        = ((3*CH_BITS+ROW_W+COL_OUT_W+7)/8)*8;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int FILL_W       = 300;

  // One smoothed interior pixel as the block should report it
  typedef struct {
    logic [CH_BITS-1:0]   red;
    logic [CH_BITS-1:0]   green;
    logic [CH_BITS-1:0]   blue;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } smoothed_px_t;

  // Line-buffer model of the filter plus the queue of smoothed pixels still owed
  class smoothing_scoreboard;
    logic [PIX_W-1:0] upper_line[MAX_W];
    logic [PIX_W-1:0] middle_line[MAX_W];
    logic [PIX_W-1:0] left_px;
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] rows_reg;
    smoothed_px_t     owed_px[$];
    int               errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      left_px   = '0;
      row_pos   = 0;
      col_pos   = 0;
      width_reg = LINE_WIDTH_RESET;
      rows_reg  = FRAME_ROWS_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [REG_W-1:0] val);
      if (idx == REG_LINE_WIDTH) width_reg = val;
      else rows_reg = val;
    endfunction

    // Advance the raster by one accepted pixel word
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int unsigned      sum;
      logic [PIX_W-1:0] right_px;
      logic [PIX_W-1:0] top_px;
      logic [PIX_W-1:0] avg;
      smoothed_px_t     res;
      w = width_reg;
      h = rows_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_W) w = MAX_W;
      if (h < MIN_DIM) h = MIN_DIM;
      r = row_pos;
      c = col_pos;
      right_px = (c + 1 < MAX_W) ? middle_line[c+1] : '0;
      top_px   = upper_line[c];

      // Emit the pixel above when this one closes its cross
      if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2) begin
        avg = '0;
        for (int k = 0; k < 3; k++) begin
          sum = left_px[CH_BITS*k +: CH_BITS] + right_px[CH_BITS*k +: CH_BITS]
              + top_px[CH_BITS*k +: CH_BITS] + px[CH_BITS*k +: CH_BITS];
          avg[CH_BITS*k +: CH_BITS] = CH_BITS'(sum >> 2);
        end
        res.red   = avg[CH_BITS-1:0];
        res.green = avg[2*CH_BITS-1:CH_BITS];
        res.blue  = avg[3*CH_BITS-1:2*CH_BITS];
        res.row   = ROW_W'(r - 1);
        res.col   = COL_OUT_W'(c);
        res.last  = (r == h - 1 && c == w - 2);
        owed_px.push_back(res);
      end

      // Shift the column through the line buffers
      left_px        = middle_line[c];
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;

      // Advance column and row, wrap at the limits
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Match an output word against the oldest owed pixel
    function void check_smoothed(logic [OUT_W-1:0] data, logic last);
      smoothed_px_t want;
      if (owed_px.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual tdata=%h tlast=%b",
                 $time, data, last);
        errors++;
        return;
      end
      want = owed_px.pop_front();
      compare_field("avg_red",    want.red,   data[CH_BITS-1:0]);
      compare_field("avg_green",  want.green, data[2*CH_BITS-1:CH_BITS]);
      compare_field("avg_blue",   want.blue,  data[3*CH_BITS-1:2*CH_BITS]);
      compare_field("out_row",    want.row,   data[3*CH_BITS +: ROW_W]);
      compare_field("out_col",    want.col,   data[3*CH_BITS+ROW_W +: COL_OUT_W]);
      compare_field("frame_last", want.last,  last);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             wr_en = 1'b0;
  logic             wr_addr = REG_LINE_WIDTH;
  logic [REG_W-1:0] wr_data = '0;

  smoothing_scoreboard sb = new();
  bit                  idle_on = 1'b0;
  int                  stall_left = 0;

  four_neighbor_rgb_smoothing #(
    .MAX_WIDTH   (MAX_W),
    .CHANNEL_BITS(CH_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #(8 * 2000000);
    $display("tb_four_neighbor_rgb_smoothing failed");
    $finish;
  end

  // Output side: check accepted words, stall in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_smoothed(m_axis_tdata, m_axis_tlast);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!rst && idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_axis_tready <= !rst;
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // Offer one pixel word, hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(px);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel());
  endtask

  // Drop valid, let every owed pixel arrive and the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [REG_W-1:0] width, input logic [REG_W-1:0] rows);
    wr_en   <= 1'b1;
    wr_addr <= REG_LINE_WIDTH;
    wr_data <= width;
    @(posedge clk);
    wr_addr <= REG_FRAME_ROWS;
    wr_data <= rows;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.write_reg(REG_LINE_WIDTH, width);
    sb.write_reg(REG_FRAME_ROWS, rows);
  endtask

  initial begin
    int          sent;
    int          sel;
    int unsigned w;
    int unsigned h;
    int unsigned w_eff;
    int unsigned h_eff;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Width above and rows below range: one full row plus two pixels of the next
    idle_on = 1'b1;
    set_geometry(12'd4095, 12'd0);
    send_random(MAX_W + 2);
    drain();

    // Narrow the line mid-row and finish the frame; fills both line buffers
    set_geometry(REG_W'(FILL_W), 12'd3);
    send_random(2 * FILL_W - 2);
    drain();

    // Smallest frame, saturated channels, then all zeros
    set_geometry(12'd1, 12'd2);
    repeat (9) send_pixel('1);
    drain();
    set_geometry(12'd2, 12'd1);
    repeat (9) send_pixel('0);
    drain();

    // Tallest frame setting on the narrowest line, first rows only
    set_geometry(12'd3, 12'd4095);
    send_random(3 * 20);
    drain();

    // Random geometries; phases often stop mid-frame
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        w = $urandom_range(100, FILL_W);
        h = $urandom_range(3, 4);
      end else if (sel == 1) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 2);
      end else if (sel < 6) begin
        w = $urandom_range(3, 40);
        h = $urandom_range(3, 8);
      end else begin
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 6);
      end
      w_eff = (w < MIN_DIM) ? MIN_DIM : w;
      h_eff = (h < MIN_DIM) ? MIN_DIM : h;
      set_geometry(REG_W'(w), REG_W'(h));
      if (sel == 0) begin
        send_random(w_eff * h_eff);
        sent += w_eff * h_eff;
      end else begin
        sel = $urandom_range(1, 3 * w_eff * h_eff);
        send_random(sel);
        sent += sel;
      end
      drain();
    end

    // Closing stretch without any idling
    idle_on = 1'b0;
    set_geometry(12'd5, 12'd4);
    send_random(60);
    drain();

    if (sb.errors == 0) begin
      $display("tb_four_neighbor_rgb_smoothing passed");
    end else begin
      $display("tb_four_neighbor_rgb_smoothing failed");
    end
    $finish;
  end

endmodule
